// ----- rtl/pfpm_pkg.sv -----
package pfpm_pkg;

   localparam int NUM_MODULES   = 8;
   localparam int MOD_AW        = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
   localparam int NUM_ERR_TYPES = 17;
   localparam int NUM_BYTES     = 7;

   localparam logic [NUM_ERR_TYPES-1:0] CRITICAL_MASK = 17'h107DF;

   // status bytes, element 0 is register 0x05, then 0x06, 0x08, 0x09, 0x0a, 0x0b, 0x33
   typedef logic [NUM_BYTES-1:0][7:0] byte_vec_type;
   typedef logic [NUM_ERR_TYPES-1:0]  flags_type;

   localparam logic [7:0] ERR_PAT [NUM_ERR_TYPES][NUM_BYTES] = '{
      '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00},
      '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08},
      '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0, 8'h00},
      '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_SET   = 1'b1;

   localparam logic [1:0] RK_EVENT   = 2'd0;
   localparam logic [1:0] RK_SUMMARY = 2'd1;
   localparam logic [1:0] RK_SET     = 2'd2;

   localparam logic [1:0] SET_OK       = 2'd0;
   localparam logic [1:0] SET_BAD_MOD  = 2'd1;
   localparam logic [1:0] SET_BAD_TYPE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/power_fault_pattern_monitor.sv -----
// Power fault pattern monitor. A check item (tuser 0) matches seven status bytes
// against 17 fixed fault patterns and updates that module's error flags, which
// live in a small synchronous flag memory: the flags are read as the item is accepted,
// the patterns are evaluated and the flags written back in the next cycle, and then
// one result leaves per cycle while the output is not stalled: an event for each
// newly raised error type in ascending order, then a summary with tlast. A set-flag
// item (tuser 1) forces one flag and returns a single status result. The next item
// is taken once the last result of the current one is loaded into the output
// register, so items are not overlapped. After reset all flags read as clear
// without any clearing pass.
module power_fault_pattern_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind
   input  logic [0:0]  req_tuser,
   // module_index, set_error_type, reg_r05, reg_r06, reg_r08, reg_r09, reg_r0a,
   // reg_r0b, reg_r33, zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_kind
   output logic [1:0]  rsp_tuser,
   // event_module, event_error_type, any_match, critical_set, set_status, zero fill
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = pfpm_pkg::MOD_AW;

   pfpm_pkg::state_type state_ff, state_in;

   // latched item
   logic                   kind_ff;
   logic [3:0]             mod_ff;
   logic [4:0]             et_ff;
   pfpm_pkg::byte_vec_type bytes_ff;

   // flag memory
   pfpm_pkg::flags_type    mem [pfpm_pkg::NUM_MODULES];
   logic [pfpm_pkg::NUM_MODULES-1:0] ent_vld_ff;
   pfpm_pkg::flags_type    rd_data_ff;
   logic                   rd_vld_ff;
   logic                   wr_en;
   pfpm_pkg::flags_type    wr_data;

   // pending results
   pfpm_pkg::flags_type    pend_ff, pend_in;
   logic [1:0]             fin_kind_ff, fin_kind_in;
   logic                   fin_any_ff, fin_any_in;
   logic                   fin_crit_ff, fin_crit_in;
   logic [1:0]             fin_status_ff, fin_status_in;

   // output register
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]             rsp_tuser_ff, rsp_tuser_in;
   logic [15:0]            rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;

   logic                   req_accept;
   logic                   slot_free;
   logic                   mod_valid;
   pfpm_pkg::flags_type    hits;
   pfpm_pkg::flags_type    old_flags;

   function automatic logic [4:0] first_set(pfpm_pkg::flags_type v);
      logic [4:0] idx;
      idx = '0;
      for (int i = pfpm_pkg::NUM_ERR_TYPES - 1; i >= 0; i--) begin
         if (v[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   pfpm_match u_match (
      .status (bytes_ff),
      .hits   (hits)
   );

   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign mod_valid  = {1'b0, mod_ff} < 5'(pfpm_pkg::NUM_MODULES);
   assign old_flags  = rd_vld_ff ? rd_data_ff : '0;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfpm_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_tuser[0];
         mod_ff   <= req_tdata[3:0];
         et_ff    <= req_tdata[8:4];
         bytes_ff <= req_tdata[64:9];
      end
      pend_ff       <= pend_in;
      fin_kind_ff   <= fin_kind_in;
      fin_any_ff    <= fin_any_in;
      fin_crit_ff   <= fin_crit_in;
      fin_status_ff <= fin_status_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tlast_ff  <= rsp_tlast_in;
   end

   // flag memory, entries not yet written read as clear
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[req_tdata[AW-1:0]];
      end
      if (wr_en) begin
         mem[mod_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            rd_vld_ff <= ent_vld_ff[req_tdata[AW-1:0]];
         end
         if (wr_en) begin
            ent_vld_ff[mod_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = (state_ff == pfpm_pkg::ST_IDLE);
      wr_en         = 1'b0;
      wr_data       = hits;
      pend_in       = pend_ff;
      fin_kind_in   = fin_kind_ff;
      fin_any_in    = fin_any_ff;
      fin_crit_in   = fin_crit_ff;
      fin_status_in = fin_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         pfpm_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = pfpm_pkg::ST_READ;
            end
         end
         pfpm_pkg::ST_READ: begin
            fin_any_in    = 1'b0;
            fin_crit_in   = 1'b0;
            fin_status_in = pfpm_pkg::SET_OK;
            pend_in       = '0;
            if (kind_ff == pfpm_pkg::KIND_SET) begin
               fin_kind_in = pfpm_pkg::RK_SET;
               wr_data     = old_flags | (pfpm_pkg::flags_type'(1) << et_ff);
               if (!mod_valid) begin
                  fin_status_in = pfpm_pkg::SET_BAD_MOD;
               end else if (et_ff >= 5'(pfpm_pkg::NUM_ERR_TYPES)) begin
                  fin_status_in = pfpm_pkg::SET_BAD_TYPE;
               end else begin
                  wr_en = 1'b1;
               end
            end else begin
               fin_kind_in = pfpm_pkg::RK_SUMMARY;
               fin_any_in  = |hits;
               if (mod_valid) begin
                  // new flags are exactly the hits; events for rising flags only
                  wr_en       = 1'b1;
                  wr_data     = hits;
                  pend_in     = hits & ~old_flags;
                  fin_crit_in = |(hits & pfpm_pkg::CRITICAL_MASK);
               end
            end
            state_in = pfpm_pkg::ST_EMIT;
         end
         pfpm_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               if (pend_ff != '0) begin
                  rsp_tuser_in = pfpm_pkg::RK_EVENT;
                  rsp_tdata_in = {4'b0, pfpm_pkg::SET_OK, 1'b0, 1'b0,
                                  first_set(pend_ff), mod_ff[2:0]};
                  rsp_tlast_in = 1'b0;
                  pend_in      = pend_ff & (pend_ff - 1'b1);
               end else begin
                  rsp_tuser_in = fin_kind_ff;
                  rsp_tdata_in = {4'b0, fin_status_ff, fin_crit_ff, fin_any_ff,
                                  5'd0, mod_ff[2:0]};
                  rsp_tlast_in = 1'b1;
                  state_in     = pfpm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pfpm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/pfpm_match.sv -----
module pfpm_match (
   input  pfpm_pkg::byte_vec_type status,
   output pfpm_pkg::flags_type    hits
);

   always_comb begin
      logic [7:0] pat;
      logic [2:0] code;
      hits = '0;
      for (int t = 0; t < pfpm_pkg::NUM_ERR_TYPES; t++) begin
         hits[t] = 1'b1;
         for (int b = 0; b < pfpm_pkg::NUM_BYTES; b++) begin
            pat = pfpm_pkg::ERR_PAT[t][b];
            if ((status[b] & pat) != pat) begin
               hits[t] = 1'b0;
            end
         end
         // error log code in the low bits of the first byte must match exactly
         code = pfpm_pkg::ERR_PAT[t][0][2:0];
         if (code != 3'd0 && code != status[0][2:0]) begin
            hits[t] = 1'b0;
         end
      end
   end

endmodule
